// ===== sv/voxel_line_walk_assert.svh =====
// Assertion macros shared by the voxel line walker RTL.
// Expects signals named clock and reset in the including module.
`ifndef VOXEL_LINE_WALK_ASSERT_SVH
`define VOXEL_LINE_WALK_ASSERT_SVH

// same-cycle implication
`define VLW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voxel_line_walk assertion failed");

// next-cycle implication
`define VLW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voxel_line_walk assertion failed");

`endif

// ===== sv/vlw_pkg.sv =====
// Shared types, sizes and constants for the voxel line walker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vlw_pkg;

   localparam int MAP_SIDE   = 512;
   localparam int MAP_HEIGHT = 64;

   localparam int XY_W = 9;
   localparam int Z_W  = 6;

   // coordinate limits of the map
   localparam int XY_LIMIT_I = (MAP_SIDE < 512) ? MAP_SIDE : 512;
   localparam int Z_LIMIT_I  = (MAP_HEIGHT < 64) ? MAP_HEIGHT : 64;
   localparam int LIM_W      = XY_W + 2;
   localparam logic [LIM_W-1:0] XY_LIMIT = LIM_W'(XY_LIMIT_I);
   localparam logic [LIM_W-1:0] Z_LIMIT  = LIM_W'(Z_LIMIT_I);

   // increments: major axis 1 << INC_SHIFT, flat minor axes INC_FLAT, other minor axes by division
   localparam int INC_SHIFT   = 10;
   localparam int DVD_W       = XY_W + INC_SHIFT;
   localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
   localparam int INC_FLAT_I  = 32'h3fffffff / MAP_SIDE;
   localparam int INC_FLAT_W  = $clog2(INC_FLAT_I + 1);
   localparam int INC_W       = (INC_FLAT_W > DVD_W) ? INC_FLAT_W : DVD_W;
   localparam int ACC_W       = INC_W + 3;
   localparam logic [INC_W-1:0] INC_MAJOR = INC_W'(1 << INC_SHIFT);
   localparam logic [INC_W-1:0] INC_FLAT  = INC_W'(INC_FLAT_I);

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_STEP,
      ST_EMIT,
      ST_BLANK
   } state_type;

   typedef struct packed {
      logic            req_type;
      logic [XY_W-1:0] start_x;
      logic [XY_W-1:0] start_y;
      logic [Z_W-1:0]  start_z;
      logic [XY_W-1:0] goal_x;
      logic [XY_W-1:0] goal_y;
      logic [Z_W-1:0]  goal_z;
   } req_word_type;

   typedef struct packed {
      logic            point_valid;
      logic [XY_W-1:0] point_x;
      logic [XY_W-1:0] point_y;
      logic [Z_W-1:0]  point_z;
      logic            last_point;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic div_start;
      logic store_inc;
      logic step;
      logic emit;
      logic blank;
   } vlw_cmd_type;

   typedef struct packed {
      logic axis_major;
      logic axis_last;
      logic div_done;
      logic out_free;
      logic walk_active;
   } vlw_status_type;

endpackage

`default_nettype wire

// ===== sv/voxel_line_walk.sv =====
// Top level of the 3D voxel line walker (fixed-point DDA).
// Depends on vlw_pkg, vlw_ctrl and vlw_datapath.
//
//   channel   ports                              word
//   request   req_valid, req_stall, req_word     req_word_type
//   response  rsp_valid, rsp_stall, rsp_word     rsp_word_type
//
// An advance word goes through accept, step and emit; an advance while idle through accept and blank.
// For a start word the two minor-axis increments go one after the other
// through a single bit-serial divider, 19 quotient bits each.
// Reset is synchronous and leaves no walk active; nothing needs clearing.
// A stalled response holds in the output register; the next request is
// still taken and waits only at its own emit or blank step.
`timescale 1ns / 1ps
`default_nettype none

module voxel_line_walk import vlw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   vlw_cmd_type    cmd;
   vlw_status_type status;

   vlw_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_start (req_word.req_type == REQ_START),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   vlw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ===== sv/vlw_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on vlw_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module vlw_div import vlw_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [XY_W-1:0]  divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [XY_W-1:0]      rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [XY_W:0]        trial;
   logic [XY_W:0]        diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, divisor};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits suffice
         rem_in = ge ? diff[XY_W-1:0] : trial[XY_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/vlw_datapath.sv =====
// Datapath of the line walker: coordinates, DDA accumulators, output word.
// Depends on vlw_pkg and vlw_div; driven by vlw_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module vlw_datapath import vlw_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire req_word_type   req_word,
   input  wire vlw_cmd_type    cmd,
   output vlw_status_type      status,
   output logic                rsp_valid,
   output rsp_word_type        rsp_word,
   input  wire logic           rsp_stall
);

`include "voxel_line_walk_assert.svh"

   logic [XY_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [Z_W-1:0]   cur_z_ff, cur_z_in;
   logic [XY_W-1:0]  tgt_x_ff, tgt_y_ff;
   logic [Z_W-1:0]   tgt_z_ff;
   logic [2:0]       dir_neg_ff;
   logic [XY_W-1:0]  abs_ff [3];
   logic [XY_W-1:0]  major_abs_ff;
   axis_type         major_ff, major_in;
   axis_type         div_axis_ff, div_axis_in;
   logic [ACC_W-1:0] acc_ff [3];
   logic [INC_W-1:0] inc_ff [3];
   logic             walk_active_ff;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   logic [XY_W:0]    dx, dy;
   logic [Z_W:0]     dz;
   logic [XY_W-1:0]  ax, ay, az;
   logic             div_done;
   logic [DVD_W-1:0] quotient;
   logic [INC_W-1:0] new_inc, half;
   logic [ACC_W-1:0] seed;
   axis_type         sel;
   logic             leaves, at_goal, last, out_free;
   logic [LIM_W-1:0] up_x, up_y, up_z;

   vlw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({major_abs_ff, INC_SHIFT'(0)}),
      .divisor  (abs_ff[div_axis_ff]),
      .done     (div_done),
      .quotient (quotient)
   );

   // deltas, magnitudes and major axis
   always_comb begin
      dx = {1'b0, tgt_x_ff} - {1'b0, cur_x_ff};
      dy = {1'b0, tgt_y_ff} - {1'b0, cur_y_ff};
      dz = {1'b0, tgt_z_ff} - {1'b0, cur_z_ff};
      ax = dx[XY_W] ? XY_W'(-dx) : dx[XY_W-1:0];
      ay = dy[XY_W] ? XY_W'(-dy) : dy[XY_W-1:0];
      az = XY_W'(dz[Z_W] ? Z_W'(-dz) : dz[Z_W-1:0]);
      if (ax >= ay && ax >= az) begin
         major_in = AXIS_X;
      end else if (ay >= az) begin
         major_in = AXIS_Y;
      end else begin
         major_in = AXIS_Z;
      end
   end

   // increment and seed for the axis in turn
   always_comb begin
      if (div_axis_ff == major_ff) begin
         new_inc = INC_MAJOR;
      end else if (abs_ff[div_axis_ff] == '0) begin
         new_inc = INC_FLAT;
      end else begin
         new_inc = INC_W'(quotient);
      end
      half = new_inc >> 1;
      seed = ACC_W'(dir_neg_ff[div_axis_ff] ? half : new_inc - half);
      unique case (div_axis_ff)
         AXIS_X:  div_axis_in = AXIS_Y;
         AXIS_Y:  div_axis_in = AXIS_Z;
         AXIS_Z:  div_axis_in = AXIS_Z;
         default: div_axis_in = AXIS_X;
      endcase
   end

   // axis that steps next, and whether the current point is the last
   always_comb begin
      if (acc_ff[2] <= acc_ff[0] && acc_ff[2] <= acc_ff[1]) begin
         sel = AXIS_Z;
      end else if (acc_ff[0] < acc_ff[1]) begin
         sel = AXIS_X;
      end else begin
         sel = AXIS_Y;
      end
      up_x = LIM_W'(cur_x_ff) + 1'b1;
      up_y = LIM_W'(cur_y_ff) + 1'b1;
      up_z = LIM_W'(cur_z_ff) + 1'b1;
      cur_x_in = dir_neg_ff[0] ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      cur_y_in = dir_neg_ff[1] ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
      cur_z_in = dir_neg_ff[2] ? cur_z_ff - 1'b1 : cur_z_ff + 1'b1;
      unique case (sel)
         AXIS_X:  leaves = dir_neg_ff[0] ? (cur_x_ff == '0) : (up_x >= XY_LIMIT);
         AXIS_Y:  leaves = dir_neg_ff[1] ? (cur_y_ff == '0) : (up_y >= XY_LIMIT);
         AXIS_Z:  leaves = dir_neg_ff[2] ? (cur_z_ff == '0) : (up_z >= Z_LIMIT);
         default: leaves = 1'b1;
      endcase
      at_goal = cur_x_ff == tgt_x_ff && cur_y_ff == tgt_y_ff && cur_z_ff == tgt_z_ff;
      last    = at_goal || leaves;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.emit) begin
            walk_active_ff <= !last;
         end
         if (cmd.emit || cmd.blank) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.capture) begin
         cur_x_ff <= req_word.start_x;
         cur_y_ff <= req_word.start_y;
         cur_z_ff <= req_word.start_z;
         tgt_x_ff <= req_word.goal_x;
         tgt_y_ff <= req_word.goal_y;
         tgt_z_ff <= req_word.goal_z;
      end else if (cmd.step) begin
         unique case (sel)
            AXIS_X:  cur_x_ff <= cur_x_in;
            AXIS_Y:  cur_y_ff <= cur_y_in;
            AXIS_Z:  cur_z_ff <= cur_z_in;
            default: cur_x_ff <= cur_x_ff;
         endcase
         acc_ff[sel] <= acc_ff[sel] + ACC_W'(inc_ff[sel]);
      end

      if (cmd.setup) begin
         dir_neg_ff   <= {dz[Z_W], dy[XY_W], dx[XY_W]};
         abs_ff[0]    <= ax;
         abs_ff[1]    <= ay;
         abs_ff[2]    <= az;
         major_ff     <= major_in;
         div_axis_ff  <= AXIS_X;
         unique case (major_in)
            AXIS_X:  major_abs_ff <= ax;
            AXIS_Y:  major_abs_ff <= ay;
            AXIS_Z:  major_abs_ff <= az;
            default: major_abs_ff <= ax;
         endcase
      end else if (cmd.store_inc) begin
         inc_ff[div_axis_ff] <= new_inc;
         acc_ff[div_axis_ff] <= seed;
         div_axis_ff         <= div_axis_in;
      end

      if (cmd.emit) begin
         rsp_word_ff.point_valid <= 1'b1;
         rsp_word_ff.point_x     <= cur_x_ff;
         rsp_word_ff.point_y     <= cur_y_ff;
         rsp_word_ff.point_z     <= cur_z_ff;
         rsp_word_ff.last_point  <= last;
      end else if (cmd.blank) begin
         rsp_word_ff <= '0;
      end
   end

   always_comb begin
      status.axis_major  = div_axis_ff == major_ff;
      status.axis_last   = div_axis_ff == AXIS_Z;
      status.div_done    = div_done;
      status.out_free    = out_free;
      status.walk_active = walk_active_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `VLW_ASSERT_NOW(a_emit_room, cmd.emit || cmd.blank, out_free)
   `VLW_ASSERT_NOW(a_step_active, cmd.step, walk_active_ff)
   `VLW_ASSERT_NOW(a_quotient_ready, cmd.store_inc && !status.axis_major, div_done)
   `VLW_ASSERT_NEXT(a_last_ends_walk, cmd.emit, walk_active_ff == !rsp_word_ff.last_point)

endmodule

`default_nettype wire

// ===== sv/vlw_ctrl.sv =====
// Sequencer of the line walker: setup, divisions, step, emit and blank.
// Depends on vlw_pkg; drives vlw_datapath through command signals.
`timescale 1ns / 1ps
`default_nettype none

module vlw_ctrl import vlw_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_is_start,
   output logic                req_stall,
   input  wire vlw_status_type status,
   output vlw_cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_is_start) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SETUP;
               end else if (status.walk_active) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_BLANK;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV_START;
         end
         ST_DIV_START: begin
            // major axis takes its fixed increment without dividing
            if (status.axis_major) begin
               cmd.store_inc = 1'b1;
               if (status.axis_last) begin
                  state_in = ST_EMIT;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.store_inc = 1'b1;
               state_in      = status.axis_last ? ST_EMIT : ST_DIV_START;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_BLANK: begin
            if (status.out_free) begin
               cmd.blank = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== test/voxel_line_walk_check.sv =====
// Checker for the voxel line walker: watches both channels, predicts each point word
// from the accepted request words and compares it with the response words in order.
// Depends on vlw_pkg for the word types, sizes and request codes.
`timescale 1ns / 1ps

module voxel_line_walk_check import vlw_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_word,
   output int                fail_count,
   output int                points_pending
);

   // predicted walker state
   logic            walking;
   logic [XY_W-1:0] pos_x, pos_y, goal_x, goal_y;
   logic [Z_W-1:0]  pos_z, goal_z;
   logic [2:0]      heading_neg;
   logic [31:0]     phase [3];
   logic [31:0]     stride [3];

   rsp_word_type expected_points [$];

   initial begin
      fail_count = 0;
      points_pending = 0;
   end

   function automatic axis_type next_axis();
      if (phase[AXIS_Z] <= phase[AXIS_X] && phase[AXIS_Z] <= phase[AXIS_Y]) return AXIS_Z;
      if (phase[AXIS_X] < phase[AXIS_Y]) return AXIS_X;
      return AXIS_Y;
   endfunction

   function automatic int stepped_coord(axis_type ax);
      int c;
      c = (ax == AXIS_X) ? int'(pos_x) : (ax == AXIS_Y) ? int'(pos_y) : int'(pos_z);
      return heading_neg[ax] ? c - 1 : c + 1;
   endfunction

   function automatic logic leaves_map(axis_type ax);
      int n;
      int lim;
      n = stepped_coord(ax);
      lim = (ax == AXIS_Z) ? Z_LIMIT_I : XY_LIMIT_I;
      return (n < 0) || (n >= lim);
   endfunction

   // current point goes out; last when at the goal or the next step would leave the map
   task automatic emit_point();
      rsp_word_type p;
      logic fin;
      fin = (pos_x == goal_x && pos_y == goal_y && pos_z == goal_z) || leaves_map(next_axis());
      p.point_valid = 1'b1;
      p.point_x = pos_x;
      p.point_y = pos_y;
      p.point_z = pos_z;
      p.last_point = fin;
      walking = !fin;
      expected_points.insert(expected_points.size(), p);
   endtask

   task automatic predict_point(input req_word_type w);
      int d [3];
      int mag [3];
      int i;
      int n;
      axis_type major;
      axis_type ax;
      logic [31:0] inc;
      if (w.req_type == REQ_START) begin
         pos_x = w.start_x;
         pos_y = w.start_y;
         pos_z = w.start_z;
         goal_x = w.goal_x;
         goal_y = w.goal_y;
         goal_z = w.goal_z;
         d[0] = int'(goal_x) - int'(pos_x);
         d[1] = int'(goal_y) - int'(pos_y);
         d[2] = int'(goal_z) - int'(pos_z);
         heading_neg = '0;
         for (i = 0; i < 3; i++) begin
            mag[i] = (d[i] < 0) ? -d[i] : d[i];
            heading_neg[i] = (d[i] < 0);
         end
         // ties go to x, then y
         if (mag[0] >= mag[1] && mag[0] >= mag[2]) major = AXIS_X;
         else if (mag[1] >= mag[2]) major = AXIS_Y;
         else major = AXIS_Z;
         for (i = 0; i < 3; i++) begin
            if (i == int'(major)) inc = 32'(1 << INC_SHIFT);
            else if (mag[i] == 0) inc = 32'(INC_FLAT_I);
            else inc = 32'((mag[major] * (1 << INC_SHIFT)) / mag[i]);
            stride[i] = inc;
            phase[i] = heading_neg[i] ? inc / 2 : inc - inc / 2;
         end
         emit_point();
      end else if (!walking) begin
         expected_points.insert(expected_points.size(), rsp_word_type'('0));
      end else begin
         ax = next_axis();
         n = stepped_coord(ax);
         case (ax)
            AXIS_X: pos_x = n[XY_W-1:0];
            AXIS_Y: pos_y = n[XY_W-1:0];
            default: pos_z = n[Z_W-1:0];
         endcase
         phase[ax] = phase[ax] + stride[ax];
         emit_point();
      end
   endtask

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_point(input rsp_word_type got);
      rsp_word_type want;
      if (expected_points.size() == 0) begin
         $error("point word with nothing expected: %h", got);
         fail_count++;
      end else begin
         want = expected_points.pop_front();
         compare_field("point_valid", want.point_valid, got.point_valid);
         compare_field("point_x", want.point_x, got.point_x);
         compare_field("point_y", want.point_y, got.point_y);
         compare_field("point_z", want.point_z, got.point_z);
         compare_field("last_point", want.last_point, got.last_point);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         walking = 1'b0;
         pos_x = '0;
         pos_y = '0;
         pos_z = '0;
         goal_x = '0;
         goal_y = '0;
         goal_z = '0;
         heading_neg = '0;
         for (int k = 0; k < 3; k++) begin
            phase[k] = '0;
            stride[k] = '0;
         end
         expected_points.delete();
      end else begin
         // response first: a word accepted on this edge cannot answer this edge's request
         if (rsp_valid && !rsp_stall) check_point(rsp_word);
         if (req_valid && !req_stall) predict_point(req_word);
      end
      points_pending <= expected_points.size();
   end

endmodule

// ===== test/voxel_line_walk_test.sv =====
// Testbench top for voxel_line_walk: clock, reset, request stimulus, response stalls
// and the verdict. Depends on vlw_pkg, voxel_line_walk and voxel_line_walk_check.
`timescale 1ns / 1ps

module voxel_line_walk_test import vlw_pkg::*;;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   int           fail_count;
   int           points_pending;

   int   words_sent = 0;
   logic calm = 1'b0;     // no idling on either side
   logic gaps_on = 1'b1;
   int   stall_left = 0;
   int   stall_clock = 0;
   logic stalls_on = 1'b1;

   voxel_line_walk u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   voxel_line_walk_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .fail_count     (fail_count),
      .points_pending (points_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response stalls in bursts, with quiet stretches between
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         stall_clock++;
         if (stall_clock % 256 == 0) stalls_on = ($urandom_range(0, 2) != 0);
         if (calm) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input req_word_type w);
      if (words_sent % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (words_sent >= 1200) calm = 1'b1;
      @(negedge clock);
   endtask

   task automatic send_start(input int sx, input int sy, input int sz,
                             input int gx, input int gy, input int gz);
      req_word_type w;
      w.req_type = REQ_START;
      w.start_x = sx[XY_W-1:0];
      w.start_y = sy[XY_W-1:0];
      w.start_z = sz[Z_W-1:0];
      w.goal_x = gx[XY_W-1:0];
      w.goal_y = gy[XY_W-1:0];
      w.goal_z = gz[Z_W-1:0];
      send_word(w);
   endtask

   // coordinates are ignored on advance, so they carry noise
   task automatic send_advance();
      req_word_type w;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      w = noise[$bits(req_word_type)-1:0];
      w.req_type = REQ_ADVANCE;
      send_word(w);
   endtask

   // biased towards the map edges so that walks run off the map
   function automatic int edge_coord(int top);
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: return top - int'($urandom_range(0, 3));
         default: return $urandom_range(0, top);
      endcase
   endfunction

   function automatic int near_coord(int s, int spread, int top);
      int g;
      g = s + int'($urandom_range(0, 2 * spread)) - spread;
      if (g < 0) g = 0;
      if (g > top) g = top;
      return g;
   endfunction

   initial begin
      int sx, sy, sz, gx, gy, gz;
      int spread, steps, kind;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle advance, single-point line, ties, each major axis, both
      // directions on x and z, start over an active walk, full-range endpoints
      send_advance();
      send_start(5, 5, 5, 5, 5, 5);
      send_advance();
      send_start(0, 0, 0, 3, 3, 3);
      repeat (4) send_advance();
      send_start(511, 511, 63, 508, 510, 63);
      repeat (2) send_advance();
      send_start(0, 0, 0, 0, 0, 63);
      repeat (2) send_advance();
      send_start(511, 0, 0, 511, 511, 0);
      repeat (2) send_advance();
      send_start(0, 511, 63, 0, 511, 60);
      repeat (2) send_advance();
      send_start(0, 0, 0, 511, 511, 63);
      send_advance();
      send_start(511, 511, 63, 0, 0, 0);
      send_advance();

      // random lines: mostly walked to the end with a few idle advances after,
      // some cut short by the next start
      while (words_sent < 1330) begin
         sx = edge_coord(511);
         sy = edge_coord(511);
         sz = edge_coord(63);
         kind = $urandom_range(0, 9);
         spread = (kind < 7) ? 6 : 40;
         if (kind == 9) begin
            gx = $urandom_range(0, 511);
            gy = $urandom_range(0, 511);
            gz = $urandom_range(0, 63);
         end else begin
            gx = near_coord(sx, spread, 511);
            gy = near_coord(sy, spread, 511);
            gz = near_coord(sz, spread, 63);
         end
         steps = (gx > sx ? gx - sx : sx - gx) + (gy > sy ? gy - sy : sy - gy)
               + (gz > sz ? gz - sz : sz - gz);
         if ($urandom_range(0, 6) == 0) steps = $urandom_range(0, steps);
         else steps += $urandom_range(0, 2);
         if (steps > 120) steps = $urandom_range(40, 120);
         send_start(sx, sy, sz, gx, gy, gz);
         repeat (steps) send_advance();
      end
      req_valid <= 1'b0;

      while (points_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
